// ===== hw/rtl/btc_pkg.sv =====
// Block type cache package: sizes, cache row layout, controller/datapath
// command and status structs. No dependencies.
package btc_pkg;

  localparam int NUM_SETS = 1023;
  localparam int NUM_WAYS = 3;
  localparam int TAG_W    = 32;
  localparam int TYPE_W   = 8;
  localparam int SET_W    = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
  localparam int WAY_W    = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;

  // floor(2^32 / NUM_SETS); block numbers are below 2^31 so the quotient
  // estimate is short by at most one.
  localparam int RECIP_W = 33;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << 32) / NUM_SETS);

  typedef logic [SET_W-1:0] set_t;
  typedef logic [WAY_W-1:0] way_t;

  typedef struct packed {
    logic [NUM_WAYS-1:0][TAG_W-1:0]  tags;
    logic [NUM_WAYS-1:0][TYPE_W-1:0] types;
    way_t                            ptr;
  } row_t;

  typedef struct packed {
    logic clear_wr;
    logic capture;
    logic mul_recip;
    logic mul_sets;
    logic reduce;
    logic read;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic out_full;
  } sts_t;

endpackage

// ===== hw/rtl/btc_req_if.sv =====
// Request channel: block number and fill type with valid/ready.
// Depends on nothing.
interface btc_req_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] block_number;
  logic signed [7:0]  fill_type;

  modport source (output valid, block_number, fill_type, input ready);
  modport sink   (input valid, block_number, fill_type, output ready);
endinterface

// ===== hw/rtl/btc_rsp_if.sv =====
// Response channel: type code, hit/error flags and counters with valid/ready.
// Depends on nothing.
interface btc_rsp_if;
  logic              valid;
  logic              ready;
  logic signed [7:0] block_type;
  logic              was_hit;
  logic              error;
  logic [31:0]       hit_count;
  logic [31:0]       miss_count;

  modport source (output valid, block_type, was_hit, error, hit_count, miss_count,
                  input ready);
  modport sink   (input valid, block_type, was_hit, error, hit_count, miss_count,
                  output ready);
endinterface

// ===== hw/rtl/btc_cfg_if.sv =====
// Configuration write channel: store_mounted bit with valid/ready.
// Depends on nothing.
interface btc_cfg_if;
  logic valid;
  logic ready;
  logic store_mounted;

  modport source (output valid, store_mounted, input ready);
  modport sink   (input valid, store_mounted, output ready);
endinterface

// ===== hw/rtl/btc_ctrl.sv =====
// Block type cache controller: reset clear sweep and per-request sequencing.
// Depends on btc_pkg.
module btc_ctrl import btc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic req_valid_i,
  output logic req_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  localparam logic [2:0] StClear  = 3'd0;
  localparam logic [2:0] StIdle   = 3'd1;
  localparam logic [2:0] StRecip  = 3'd2;
  localparam logic [2:0] StSets   = 3'd3;
  localparam logic [2:0] StReduce = 3'd4;
  localparam logic [2:0] StRead   = 3'd5;
  localparam logic [2:0] StResp   = 3'd6;

  logic [2:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    req_ready_o = 1'b0;
    case (state_q)
      StClear: begin
        cmd_o.clear_wr = 1'b1;
        if (sts_i.clear_last) state_d = StIdle;
      end
      StIdle: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = StRecip;
        end
      end
      StRecip: begin
        cmd_o.mul_recip = 1'b1;
        state_d         = StSets;
      end
      StSets: begin
        cmd_o.mul_sets = 1'b1;
        state_d        = StReduce;
      end
      StReduce: begin
        cmd_o.reduce = 1'b1;
        state_d      = StRead;
      end
      StRead: begin
        cmd_o.read = 1'b1;
        state_d    = StResp;
      end
      StResp: begin
        if (!sts_i.out_full) begin
          cmd_o.commit = 1'b1;
          state_d      = StIdle;
        end
      end
      default: state_d = StClear;
    endcase
  end

endmodule

// ===== hw/rtl/btc_datapath.sv =====
// Block type cache datapath: set index reduction, cache row memory, hit
// logic, counters, config register and output register. Depends on btc_pkg.
module btc_datapath import btc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cmd_t               cmd_i,
  output sts_t               sts_o,
  input  logic signed [31:0] block_number_i,
  input  logic signed [7:0]  fill_type_i,
  input  logic               cfg_valid_i,
  input  logic               cfg_mounted_i,
  output logic               cfg_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [7:0]  block_type_o,
  output logic               was_hit_o,
  output logic               error_o,
  output logic [31:0]        hit_count_o,
  output logic [31:0]        miss_count_o
);

  row_t        mem [NUM_SETS];
  row_t        row_q;
  set_t        clr_q;
  set_t        set_q;
  logic        mounted_q;
  logic [31:0] blk_q;
  logic [7:0]  fill_q;
  logic        err_q;
  logic [63:0] prod1_q;
  logic [31:0] prod2_q;
  logic [31:0] hits_q, misses_q;
  logic        out_valid_q;
  logic [7:0]  out_type_q;
  logic        out_hit_q, out_err_q;

  logic [30:0] quot;
  logic [31:0] rem;
  logic        hit;
  way_t        hit_way, nxt_way;
  row_t        wrow;
  logic        mem_we;
  set_t        mem_waddr;
  row_t        mem_wdata;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mounted_q <= 1'b0;
    end else if (cfg_valid_i) begin
      mounted_q <= cfg_mounted_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clear_wr) begin
      clr_q <= clr_q + 1'b1;
    end
  end

  assign sts_o.clear_last = (clr_q == SET_W'(NUM_SETS - 1));
  assign sts_o.out_full   = out_valid_q && !out_ready_i;

  // set = blk mod NUM_SETS via reciprocal multiply and one correction
  assign quot = prod1_q[62:32];
  assign rem  = blk_q - prod2_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      blk_q  <= block_number_i;
      fill_q <= fill_type_i;
      err_q  <= (block_number_i == 32'sd0) || block_number_i[31] || !mounted_q;
    end
    if (cmd_i.mul_recip) prod1_q <= 64'(blk_q[30:0]) * 64'(RECIP);
    if (cmd_i.mul_sets)  prod2_q <= 32'({1'b0, quot}) * 32'(NUM_SETS);
    if (cmd_i.reduce) begin
      set_q <= (rem >= 32'(NUM_SETS)) ? SET_W'(rem - 32'(NUM_SETS)) : SET_W'(rem);
    end
  end

  always_comb begin
    hit     = 1'b0;
    hit_way = '0;
    for (int w = 0; w < NUM_WAYS; w++) begin
      if (!hit && row_q.tags[w] == blk_q) begin
        hit     = 1'b1;
        hit_way = way_t'(w);
      end
    end
  end

  assign nxt_way = (row_q.ptr == WAY_W'(NUM_WAYS - 1)) ? '0 : row_q.ptr + 1'b1;

  always_comb begin
    wrow = row_q;
    if (hit) begin
      wrow.ptr = hit_way;
    end else begin
      wrow.ptr            = nxt_way;
      wrow.tags[nxt_way]  = blk_q;
      wrow.types[nxt_way] = fill_q;
    end
  end

  assign mem_we    = cmd_i.clear_wr || (cmd_i.commit && !err_q);
  assign mem_waddr = cmd_i.clear_wr ? clr_q : set_q;
  assign mem_wdata = cmd_i.clear_wr ? '0 : wrow;

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (cmd_i.read) row_q <= mem[set_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hits_q      <= '0;
      misses_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.commit && !err_q) begin
        if (hit) hits_q   <= hits_q + 1'b1;
        else     misses_q <= misses_q + 1'b1;
      end
      if (cmd_i.commit)     out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_err_q  <= err_q;
      out_hit_q  <= !err_q && hit;
      out_type_q <= err_q ? 8'd0 : (hit ? row_q.types[hit_way] : fill_q);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign block_type_o = out_type_q;
  assign was_hit_o    = out_hit_q;
  assign error_o      = out_err_q;
  assign hit_count_o  = hits_q;
  assign miss_count_o = misses_q;

endmodule

// ===== hw/rtl/block_type_set_assoc_cache.sv =====
// Block type cache top level: 3-way set-associative cache of type codes.
// Depends on btc_pkg, btc_req_if, btc_rsp_if, btc_cfg_if, btc_ctrl, btc_datapath.
//
//   channel  dir  payload                                        transfer
//   req_i    in   block_number[31:0]s, fill_type[7:0]s           valid & ready
//   rsp_o    out  block_type[7:0]s, was_hit, error,
//                 hit_count[31:0], miss_count[31:0]              valid & ready
//   cfg_i    in   store_mounted                                  valid & ready
//
// Requests are handled one at a time: set reduction (two multiplies, one
// correction), a row read and a row write-back of the single-port cache memory.
// After reset a clear sweep zeroes tags and pointers; req_i is not ready
// meanwhile. cfg_i is always ready.
// The result is held in an output register; a stalled rsp_o holds the next
// request at write-back until the register frees.
module block_type_set_assoc_cache import btc_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  btc_req_if.sink   req_i,
  btc_rsp_if.source rsp_o,
  btc_cfg_if.sink   cfg_i
);

  cmd_t cmd;
  sts_t sts;

  btc_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  btc_datapath u_dp (
    .clk_i,
    .rst_ni,
    .cmd_i          (cmd),
    .sts_o          (sts),
    .block_number_i (req_i.block_number),
    .fill_type_i    (req_i.fill_type),
    .cfg_valid_i    (cfg_i.valid),
    .cfg_mounted_i  (cfg_i.store_mounted),
    .cfg_ready_o    (cfg_i.ready),
    .out_valid_o    (rsp_o.valid),
    .out_ready_i    (rsp_o.ready),
    .block_type_o   (rsp_o.block_type),
    .was_hit_o      (rsp_o.was_hit),
    .error_o        (rsp_o.error),
    .hit_count_o    (rsp_o.hit_count),
    .miss_count_o   (rsp_o.miss_count)
  );

endmodule

// ===== hw/rtl/btc_checker.sv =====
// Port-level checker for the block type cache, bound to the top level.
// Depends on block_type_set_assoc_cache and its interfaces.
module btc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       req_valid_i,
  input logic       req_ready_i,
  input logic       rsp_valid_i,
  input logic       rsp_ready_i,
  input logic [7:0] rsp_type_i,
  input logic       rsp_hit_i,
  input logic       rsp_err_i
);

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i)
    else $error("response dropped while stalled");

  a_err_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_err_i |-> rsp_type_i == 8'd0 && !rsp_hit_i)
    else $error("error response with nonzero type or hit");

  a_hit_no_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_hit_i |-> !rsp_err_i)
    else $error("hit flagged on error response");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request taken while previous in flight");

endmodule

bind block_type_set_assoc_cache btc_checker u_btc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req_i.valid),
  .req_ready_i (req_i.ready),
  .rsp_valid_i (rsp_o.valid),
  .rsp_ready_i (rsp_o.ready),
  .rsp_type_i  (rsp_o.block_type),
  .rsp_hit_i   (rsp_o.was_hit),
  .rsp_err_i   (rsp_o.error)
);

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench for block_type_set_assoc_cache: checks every rsp_o transfer against a cache predictor.
// Depends on btc_pkg, btc_req_if, btc_rsp_if, btc_cfg_if and the block_type_set_assoc_cache RTL.
module tb_top;
  import btc_pkg::*;

  localparam int IDLE_LIMIT = 4000;

  typedef struct packed {
    logic signed [31:0] block_number;
    logic signed [7:0]  fill_type;
  } type_req_t;

  typedef struct packed {
    logic signed [7:0] block_type;
    logic              was_hit;
    logic              error;
    logic [31:0]       hit_count;
    logic [31:0]       miss_count;
  } type_rsp_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  btc_req_if req_if ();
  btc_rsp_if rsp_if ();
  btc_cfg_if cfg_if ();

  block_type_set_assoc_cache DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if),
    .cfg_i  (cfg_if)
  );

  always #1 clk_i = ~clk_i;

  // predictor state
  logic [31:0] tag_mem [NUM_SETS*NUM_WAYS];
  logic [7:0]  type_mem [NUM_SETS*NUM_WAYS];
  int unsigned way_ptr [NUM_SETS];
  logic [31:0] hits_pred;
  logic [31:0] misses_pred;
  logic        mounted_pred;

  type_req_t pending_reqs [$];
  type_rsp_t type_expect_q [$];
  int        mismatches;
  int        idle_cycles;
  int        hot_sets [8];

  function automatic type_rsp_t classify_block(type_req_t rq);
    type_rsp_t   r;
    int unsigned bn;
    int unsigned set;
    int unsigned base;
    int unsigned nxt;
    bit          hit;
    r   = '0;
    hit = 1'b0;
    bn  = rq.block_number;
    if (rq.block_number[31] || rq.block_number == 0 || !mounted_pred) begin
      r.error      = 1'b1;
      r.hit_count  = hits_pred;
      r.miss_count = misses_pred;
      return r;
    end
    set  = bn % NUM_SETS;
    base = set * NUM_WAYS;
    for (int w = 0; w < NUM_WAYS; w++) begin
      if (!hit && tag_mem[base+w] == bn) begin
        hit          = 1'b1;
        way_ptr[set] = w;
        r.block_type = type_mem[base+w];
        hits_pred    = hits_pred + 1;
      end
    end
    if (!hit) begin
      nxt = way_ptr[set] + 1;
      if (nxt >= NUM_WAYS) nxt = 0;
      way_ptr[set]        = nxt;
      tag_mem[base+nxt]   = bn;
      type_mem[base+nxt]  = rq.fill_type;
      r.block_type        = rq.fill_type;
      misses_pred         = misses_pred + 1;
    end
    r.was_hit    = hit;
    r.hit_count  = hits_pred;
    r.miss_count = misses_pred;
    return r;
  endfunction

  // mostly blocks that collide in a few hot sets, plus raw and edge values
  function automatic type_req_t random_req();
    type_req_t   rq;
    int unsigned pick;
    int unsigned set;
    int unsigned k;
    pick         = $urandom_range(0, 99);
    rq.fill_type = 8'($urandom());
    if (pick < 70) begin
      set = hot_sets[$urandom_range(0, 7)];
      k   = $urandom_range(0, 5);
      if (k == 5) k = (32'h7FFF_FFFF - set) / NUM_SETS;
      rq.block_number = set + k * NUM_SETS;
    end else if (pick < 90) begin
      rq.block_number = $urandom();
    end else begin
      case ($urandom_range(0, 4))
        0: rq.block_number = 0;
        1: rq.block_number = -1;
        2: rq.block_number = 32'h8000_0000;
        3: rq.block_number = 32'h7FFF_FFFF;
        default: rq.block_number = 1;
      endcase
    end
    return rq;
  endfunction

  task automatic push_req(input int blk, input int fill);
    type_req_t rq;
    rq.block_number = blk;
    rq.fill_type    = 8'(fill);
    pending_reqs.push_back(rq);
  endtask

  task automatic push_random(input int count);
    for (int i = 0; i < count; i++) pending_reqs.push_back(random_req());
  endtask

  task automatic drain_requests();
    @(negedge clk_i);
    while (pending_reqs.size() != 0 || req_if.valid || type_expect_q.size() != 0)
      @(negedge clk_i);
  endtask

  task automatic write_mount(input logic v);
    @(posedge clk_i);
    cfg_if.valid         <= 1'b1;
    cfg_if.store_mounted <= v;
    do @(posedge clk_i); while (!cfg_if.ready);
    mounted_pred = v;
    cfg_if.valid <= 1'b0;
  endtask

  // request driver: bursts with random gaps
  int burst_left = 0;
  int gap_left   = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (!(req_if.valid && !req_if.ready)) begin
        if (req_if.valid && req_if.ready)
          type_expect_q.push_back(classify_block({req_if.block_number, req_if.fill_type}));
        if (gap_left > 0) begin
          gap_left--;
          req_if.valid <= 1'b0;
        end else if (pending_reqs.size() != 0) begin
          type_req_t rq;
          rq = pending_reqs.pop_front();
          req_if.valid        <= 1'b1;
          req_if.block_number <= rq.block_number;
          req_if.fill_type    <= rq.fill_type;
          if (burst_left > 0) burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
          end
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // response monitor and stall pattern
  logic [15:0] stall_pat = 16'hFFFF;
  int          stall_idx = 0;
  int          pat_age   = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (rsp_if.valid && rsp_if.ready) begin
        type_rsp_t got;
        type_rsp_t want;
        got = {rsp_if.block_type, rsp_if.was_hit, rsp_if.error,
               rsp_if.hit_count, rsp_if.miss_count};
        if (type_expect_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected transfer: type %0d hit %0b err %0b hits %0d misses %0d",
                     got.block_type, got.was_hit, got.error, got.hit_count, got.miss_count);
        end else begin
          want = type_expect_q.pop_front();
          if (got.block_type !== want.block_type || got.was_hit !== want.was_hit ||
              got.error !== want.error || got.hit_count !== want.hit_count ||
              got.miss_count !== want.miss_count) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp %0d %0b %0b %0d %0d / got %0d %0b %0b %0d %0d",
                       want.block_type, want.was_hit, want.error, want.hit_count,
                       want.miss_count, got.block_type, got.was_hit, got.error,
                       got.hit_count, got.miss_count);
          end
        end
      end
      rsp_if.ready <= stall_pat[stall_idx];
      stall_idx = (stall_idx + 1) % 16;
      pat_age++;
      if (pat_age == 97) begin
        pat_age   = 0;
        stall_pat = ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom()) | 16'h1);
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
        (cfg_if.valid && cfg_if.ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  initial begin
    req_if.valid         = 1'b0;
    req_if.block_number  = '0;
    req_if.fill_type     = '0;
    rsp_if.ready         = 1'b0;
    cfg_if.valid         = 1'b0;
    cfg_if.store_mounted = 1'b0;
    mismatches  = 0;
    idle_cycles = 0;
    hits_pred   = '0;
    misses_pred = '0;
    mounted_pred = 1'b0;
    for (int i = 0; i < NUM_SETS*NUM_WAYS; i++) begin
      tag_mem[i]  = '0;
      type_mem[i] = '0;
    end
    for (int i = 0; i < NUM_SETS; i++) way_ptr[i] = 0;
    hot_sets[0] = 0;
    hot_sets[1] = 1;
    hot_sets[2] = 511;
    hot_sets[3] = NUM_SETS - 1;
    for (int i = 4; i < 8; i++) hot_sets[i] = $urandom_range(0, NUM_SETS - 1);

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // no store: everything errors
    write_mount(1'b0);
    push_req(5, 1);
    push_req(32'h7FFF_FFFF, 127);
    push_req(-1, -128);
    drain_requests();

    write_mount(1'b1);
    push_req(1, -128);
    push_req(1, 5);
    push_req(0, 0);
    push_req(-1, 7);
    push_req(32'h8000_0000, -1);
    push_req(32'h7FFF_FFFF, 127);
    push_req(32'h7FFF_FFFF, 0);
    push_req(1 + NUM_SETS, 3);
    push_req(1 + 2*NUM_SETS, 4);
    push_req(1, 9);
    push_req(1 + 3*NUM_SETS, -5);
    push_req(1, 11);
    push_req(1 + NUM_SETS, 12);
    push_req(NUM_SETS, -128);
    push_req(2*NUM_SETS, 127);
    push_req(NUM_SETS, 0);
    push_req(NUM_SETS - 1, 1);
    push_random(600);
    drain_requests();

    // unmounted: state must survive untouched
    write_mount(1'b0);
    push_random(150);
    drain_requests();

    write_mount(1'b1);
    push_random(1000);
    drain_requests();

    repeat (20) @(posedge clk_i);
    @(negedge clk_i);
    mismatches += type_expect_q.size();
    if (mismatches == 0)
      $display("tb_top: clean");
    else
      $display("tb_top: errors");
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/btc_pkg.sv
hw/rtl/btc_req_if.sv
hw/rtl/btc_rsp_if.sv
hw/rtl/btc_cfg_if.sv
hw/rtl/btc_ctrl.sv
hw/rtl/btc_datapath.sv
hw/rtl/block_type_set_assoc_cache.sv
hw/rtl/btc_checker.sv
sim/tb_top.sv
